FILE: rtl/core/arr_pkg.sv
// shared constants for the aspect ratio reducer
`timescale 1ns / 1ps

package arr_pkg;

	// default operand width
	localparam int unsigned VALUE_WIDTH_DEF = 32;

endpackage

FILE: rtl/core/aspect_ratio_reducer.sv
// aspect ratio reducer: binary gcd and two restoring divisions on one shared subtractor
// phases: binary gcd, shifting back the k shared factors of two, a restoring division of
//   each input by the gcd, then the output step; two zero inputs go straight to the output step
// input: in_stall holds off a new transaction until the sequencer is back in idle, also
//   during output stalls; a finished result waits in the output register while the next one runs
// reset: arst_n clears the sequencer and output valid; payload registers are not reset
`timescale 1ns / 1ps

module aspect_ratio_reducer #(
	parameter int unsigned VALUE_WIDTH = arr_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [VALUE_WIDTH-1:0] first_value,
	input  logic [VALUE_WIDTH-1:0] second_value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [VALUE_WIDTH-1:0] ratio_first,
	output logic [VALUE_WIDTH-1:0] ratio_second,
	output logic [VALUE_WIDTH-1:0] common_divisor,
	output logic                   both_zero
);

	localparam int unsigned W     = VALUE_WIDTH;
	localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

	// sequencer codes
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_GCD  = 3'd1;
	localparam logic [2:0] ST_SHL  = 3'd2;
	localparam logic [2:0] ST_DIV1 = 3'd3;
	localparam logic [2:0] ST_DIV2 = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0]       state_q;
	logic [W-1:0]     a_q;
	logic [W-1:0]     b_q;
	logic [W-1:0]     x_q;
	logic [W-1:0]     y_q;
	logic [W-1:0]     g_q;
	logic [W-1:0]     rf_q;
	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] cnt_q;
	logic             zero_q;

	logic             out_valid_q;
	logic [W-1:0]     ratio_first_q;
	logic [W-1:0]     ratio_second_q;
	logic [W-1:0]     common_divisor_q;
	logic             both_zero_q;

	logic [W:0]       sub_a;
	logic [W:0]       sub_b;
	logic [W:0]       diff;
	logic             borrow;
	logic [W-1:0]     quo_next;
	logic [W-1:0]     rem_next;
	logic             in_accept;
	logic             out_take;
	logic             out_free;
	logic             is_div;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign is_div    = (state_q == ST_DIV1) || (state_q == ST_DIV2);

	// shared subtractor: compare/subtract for gcd, trial subtract for division
	always_comb begin
		if (is_div) begin
			sub_a = {x_q, y_q[W-1]};
			sub_b = {1'b0, g_q};
		end else begin
			sub_a = {1'b0, x_q};
			sub_b = {1'b0, y_q};
		end
		diff   = sub_a - sub_b;
		borrow = diff[W];
	end

	// one restoring division step
	always_comb begin
		quo_next = {y_q[W-2:0], !borrow};
		rem_next = borrow ? sub_a[W-1:0] : diff[W-1:0];
	end

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_GCD;
					end
				end
				ST_GCD: begin
					if ((x_q == '0) || (y_q == '0)) begin
						state_q <= ((x_q | y_q) == '0) ? ST_FIN : ST_SHL;
					end
				end
				ST_SHL: begin
					if (k_q == '0) begin
						state_q <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					a_q <= first_value;
					b_q <= second_value;
					x_q <= first_value;
					y_q <= second_value;
					k_q <= '0;
				end
			end
			ST_GCD: begin
				priority if ((x_q == '0) || (y_q == '0)) begin
					g_q    <= x_q | y_q;
					zero_q <= ((x_q | y_q) == '0);
					rf_q   <= '0;
					y_q    <= '0;
				end else if (!x_q[0] && !y_q[0]) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					k_q <= k_q + CNT_W'(1);
				end else if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (borrow) begin
					x_q <= y_q;
					y_q <= x_q;
				end else begin
					x_q <= diff[W:1];
				end
			end
			ST_SHL: begin
				if (k_q == '0) begin
					x_q   <= '0;
					y_q   <= a_q;
					cnt_q <= '0;
				end else begin
					g_q <= g_q << 1;
					k_q <= k_q - CNT_W'(1);
				end
			end
			ST_DIV1: begin
				if (cnt_q == CNT_LAST) begin
					rf_q  <= quo_next;
					x_q   <= '0;
					y_q   <= b_q;
					cnt_q <= '0;
				end else begin
					x_q   <= rem_next;
					y_q   <= quo_next;
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			ST_DIV2: begin
				x_q   <= rem_next;
				y_q   <= quo_next;
				cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			ratio_first_q    <= rf_q;
			ratio_second_q   <= y_q;
			common_divisor_q <= g_q;
			both_zero_q      <= zero_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign ratio_first    = ratio_first_q;
	assign ratio_second   = ratio_second_q;
	assign common_divisor = common_divisor_q;
	assign both_zero      = both_zero_q;

	// checks
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && both_zero |->
			(common_divisor == '0) && (ratio_first == '0) && (ratio_second == '0))
		else $error("both-zero result carries nonzero fields");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !both_zero |-> (common_divisor != '0))
		else $error("zero divisor on a regular result");

	a_div_operand: assert property (@(posedge clk) disable iff (!arst_n)
		is_div |-> (g_q != '0))
		else $error("division started with a zero divisor");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (state_q == ST_GCD))
		else $error("accepted transaction did not start the gcd phase");

endmodule
